>>> rtl/hamming_sec_encode_check_unit_assert.svh
// Assertion macros for the Hamming SEC encode/check unit.
// Needs clk_i and rst_ni in scope at the place of use.
`ifndef HAMMING_SEC_ENCODE_CHECK_UNIT_ASSERT_SVH
`define HAMMING_SEC_ENCODE_CHECK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HSEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HSEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define HSEC_ASSERT(lbl, prop, msg)
`define HSEC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/hsec_pkg.sv
// Types, codes and constant helpers for the Hamming SEC encode/check unit.
// No dependencies.
package hsec_pkg;

  localparam int HsecWordW  = 63;  // longest code word
  localparam int HsecDataW  = 57;  // most data bits that fit in HsecWordW
  localparam int HsecSynW   = 6;
  localparam int HsecCheckW = 6;   // check bits at positions 1,2,4,...,32

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_CHECK  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_NONE          = 2'd0,
    ST_CORRECTED     = 2'd1,
    ST_UNCORRECTABLE = 2'd2
  } status_e;

  typedef struct packed {
    logic [HsecSynW-1:0]  n;       // code length
    logic [HsecDataW-1:0] m_mask;
    logic [HsecWordW-1:0] n_mask;
  } hsec_cfg_t;

  typedef struct packed {
    status_e              status;
    logic [HsecSynW-1:0]  syndrome;
    logic [HsecWordW-1:0] code_word;
  } hsec_res_t;

  // Position (1-based) of data bit d: the d-th position that is not a power of two.
  function automatic int data_pos(int d);
    int cnt;
    int res;
    cnt = 0;
    res = 0;
    for (int p = 1; p <= HsecWordW; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == d && res == 0) res = p;
        cnt++;
      end
    end
    return res;
  endfunction

  // Code word bits whose position number has bit k set.
  function automatic logic [HsecWordW-1:0] pos_mask(int k);
    logic [HsecWordW-1:0] msk;
    msk = '0;
    for (int p = 1; p <= HsecWordW; p++) begin
      if (((p >> k) & 1) != 0) msk[p-1] = 1'b1;
    end
    return msk;
  endfunction

  // Least r with m + r + 1 <= 2^r.
  function automatic logic [2:0] check_bits(logic [HsecSynW-1:0] m);
    logic [2:0] r;
    r = 3'd6;
    for (int i = 6; i >= 1; i--) begin
      if ({1'b0, m} + 7'(i) + 7'd1 <= 7'(1 << i)) r = 3'(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/hamming_sec_encode_check_unit.sv
// Hamming single-error-correcting encoder and checker, one request per clock cycle
// unless the output stalls. A request is registered in the input stage, passes one
// level of XOR trees and a flip decoder, and lands in the result register, which
// raises m_axis_tvalid. m_axis_tready low with a result waiting stalls both stages;
// s_axis_tready follows combinationally. data_length (reset 57) sets the code length;
// write it only while no request is in flight. Depends on hsec_pkg and
// hamming_sec_encode_check_unit_assert.svh.
`include "hamming_sec_encode_check_unit_assert.svh"
module hamming_sec_encode_check_unit #(
  parameter int MAX_DATA_BITS = 57
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [5:0]  cfg_wr_data_i,   // data_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,    // [62:0] word, [63] zero
  input  logic        s_axis_tuser,    // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata     // [62:0] code_word, [68:63] syndrome,
                                       // [70:69] status, [71] zero
);
  import hsec_pkg::*;

  logic [HsecSynW-1:0]  data_length_q;
  logic [HsecSynW-1:0]  m_eff;
  logic [HsecSynW-1:0]  n_len;
  hsec_cfg_t            cfg;

  logic                 s1_valid_q;
  logic                 s1_kind_q;
  logic [HsecWordW-1:0] s1_word_q;
  logic                 out_valid_q;
  hsec_res_t            out_q;
  hsec_res_t            res_d;
  logic                 adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_length_q <= 6'd57;
    end else if (cfg_wr_en_i) begin
      data_length_q <= cfg_wr_data_i;
    end
  end

  always_comb begin
    if (data_length_q == '0) begin
      m_eff = 6'd1;
    end else if (data_length_q > 6'(MAX_DATA_BITS)) begin
      m_eff = 6'(MAX_DATA_BITS);
    end else begin
      m_eff = data_length_q;
    end
    n_len      = m_eff + {3'b000, check_bits(m_eff)};
    cfg.n      = n_len;
    cfg.m_mask = ~({HsecDataW{1'b1}} << m_eff);
    cfg.n_mask = ~({HsecWordW{1'b1}} << n_len);
  end

  assign adv2          = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (adv2) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_kind_q <= s_axis_tuser;
      s1_word_q <= s_axis_tdata[HsecWordW-1:0];
    end
    if (adv2 && s1_valid_q) begin
      out_q <= res_d;
    end
  end

  hsec_core u_core (
    .cfg_i  (cfg),
    .kind_i (s1_kind_q),
    .word_i (s1_word_q),
    .res_o  (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.status, out_q.syndrome, out_q.code_word};

  `HSEC_ASSERT(a_accept_lands, (s_axis_tvalid && s_axis_tready) |=> s1_valid_q, "accepted request lost")
  `HSEC_ASSERT_IMP(a_syn_zero_none, out_valid_q, (out_q.syndrome == '0) == (out_q.status == ST_NONE), "status and syndrome disagree")
  `HSEC_ASSERT_IMP(a_cw_in_range, out_valid_q, (out_q.code_word & ~cfg.n_mask) == '0, "code word beyond code length")
  `HSEC_ASSERT_IMP(a_corr_in_range, out_valid_q && (out_q.status == ST_CORRECTED), out_q.syndrome <= cfg.n, "correction beyond code length")

endmodule

>>> rtl/hsec_core.sv
// Combinational encode / syndrome / correct datapath for one item.
// Depends on hsec_pkg.
module hsec_core (
  input  hsec_pkg::hsec_cfg_t              cfg_i,
  input  logic                             kind_i,
  input  logic [hsec_pkg::HsecWordW-1:0]   word_i,
  output hsec_pkg::hsec_res_t              res_o
);
  import hsec_pkg::*;

  logic [HsecDataW-1:0] data_m;
  logic [HsecWordW-1:0] scat;
  logic [HsecWordW-1:0] sel;
  logic [HsecSynW-1:0]  syn;
  logic [HsecWordW-1:0] enc_cw;
  logic [HsecWordW-1:0] flip;
  logic                 syn_ok;

  assign data_m = word_i[HsecDataW-1:0] & cfg_i.m_mask;

  // Data bits onto the non-power-of-two positions.
  for (genvar g = 0; g < HsecDataW; g++) begin : g_scatter
    localparam int P = data_pos(g);
    assign scat[P-1] = data_m[g];
  end
  for (genvar j = 0; j < HsecCheckW; j++) begin : g_chk_zero
    assign scat[(1 << j) - 1] = 1'b0;
  end

  // One set of XOR trees serves both directions.
  assign sel = (kind_i == KIND_CHECK) ? (word_i & cfg_i.n_mask) : scat;

  for (genvar k = 0; k < HsecSynW; k++) begin : g_syn
    localparam logic [HsecWordW-1:0] Msk = pos_mask(k);
    assign syn[k] = ^(sel & Msk);
  end

  always_comb begin
    enc_cw = scat;
    for (int j = 0; j < HsecCheckW; j++) begin
      enc_cw[(1 << j) - 1] = syn[j];
    end
    enc_cw = enc_cw & cfg_i.n_mask;
  end

  assign syn_ok = (syn != '0) && (syn <= cfg_i.n);
  assign flip   = {{(HsecWordW-1){1'b0}}, 1'b1} << (syn - 6'd1);

  always_comb begin
    res_o = '{status: ST_NONE, syndrome: '0, code_word: enc_cw};
    if (kind_i == KIND_CHECK) begin
      res_o.syndrome  = syn;
      res_o.code_word = syn_ok ? (sel ^ flip) : sel;
      if (syn == '0) begin
        res_o.status = ST_NONE;
      end else if (syn_ok) begin
        res_o.status = ST_CORRECTED;
      end else begin
        res_o.status = ST_UNCORRECTABLE;
      end
    end
  end

endmodule
